// File: hw/rtl/bba_pkg.sv
`timescale 1ns / 1ps
package bba_pkg;

    localparam int MIN_ORDER_DEF    = 5;
    localparam int MAX_ORDER_DEF    = 16;
    localparam int HEADER_BYTES_DEF = 18;

    localparam int ORD_W  = 5;
    localparam int ADDR_W = 32;
    localparam int REQ_W  = 16;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_BLOCK  = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_BAD_FREE  = 2'd3
    } status_t;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic REG_POOL_ORDER   = 1'b0;
    localparam logic REG_BASE_ADDRESS = 1'b1;

    typedef struct packed {
        logic [ORD_W-1:0]  want;
        logic              too_large;
        logic [ADDR_W-1:0] offset;
        logic              addr_bad;
    } req_info_t;

    typedef struct packed {
        logic              done;
        status_t           status;
        logic [ORD_W-1:0]  order;
        logic [ADDR_W-1:0] offset;
        logic              has_addr;
    } result_t;

endpackage

// File: hw/rtl/buddy_block_allocator_core.sv
`timescale 1ns / 1ps
// allocate: scans node rows from the wanted level up, then splits the found block down to it
// no free block: reported once all levels are scanned; request too large: rejected at once
// free: merges while the buddy is free; rejected free: bad address or no live grant
// one request at a time: start is taken when busy is low, next start in the cycle done is high
// the receiver cannot stall: done is high for exactly one cycle per result
// after reset or a pool_order write, a clearing pass over node and grant memories holds busy
module buddy_block_allocator_core #(
    parameter int MIN_ORDER    = bba_pkg::MIN_ORDER_DEF,
    parameter int MAX_ORDER    = bba_pkg::MAX_ORDER_DEF,
    parameter int HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    output logic                        done,
    input  logic                        kind,
    input  logic [bba_pkg::REQ_W-1:0]   request_bytes,
    input  logic [bba_pkg::ADDR_W-1:0]  release_address,
    output logic [bba_pkg::ADDR_W-1:0]  granted_address,
    output logic [1:0]                  status,
    output logic [bba_pkg::ORD_W-1:0]   block_order,
    input  logic                        wr_en,
    input  logic                        wr_index,
    input  logic [bba_pkg::ADDR_W-1:0]  wr_data
);

    logic [bba_pkg::ORD_W-1:0]  pool_order_reg;
    logic [bba_pkg::ADDR_W-1:0] base_reg;
    logic                       kind_reg;
    logic [bba_pkg::REQ_W-1:0]  bytes_reg;
    logic [bba_pkg::ADDR_W-1:0] rel_reg;
    logic [bba_pkg::ORD_W-1:0]  pool;
    logic                       clear_req;
    logic                       accept;
    bba_pkg::req_info_t         info;
    bba_pkg::result_t           res;

    assign accept    = start && !busy;
    assign clear_req = wr_en && (wr_index == bba_pkg::REG_POOL_ORDER);

    always_comb
    begin
        priority if (pool_order_reg < bba_pkg::ORD_W'(MIN_ORDER))
        begin
            pool = bba_pkg::ORD_W'(MIN_ORDER);
        end
        else if (pool_order_reg > bba_pkg::ORD_W'(MAX_ORDER))
        begin
            pool = bba_pkg::ORD_W'(MAX_ORDER);
        end
        else
        begin
            pool = pool_order_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_order_reg <= bba_pkg::ORD_W'(16);
            base_reg       <= '0;
        end
        else if (wr_en)
        begin
            if (wr_index == bba_pkg::REG_POOL_ORDER)
            begin
                pool_order_reg <= wr_data[bba_pkg::ORD_W-1:0];
            end
            else
            begin
                base_reg <= wr_data;
            end
        end
    end

    // request beat capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            bytes_reg <= request_bytes;
            rel_reg   <= release_address;
        end
    end

    bba_decode #(
        .MIN_ORDER    (MIN_ORDER),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_decode (
        .request_bytes   (bytes_reg),
        .release_address (rel_reg),
        .base_address    (base_reg),
        .pool            (pool),
        .info            (info)
    );

    bba_seq #(
        .MIN_ORDER (MIN_ORDER),
        .MAX_ORDER (MAX_ORDER)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear_req (clear_req),
        .start     (accept),
        .kind      (kind_reg),
        .info      (info),
        .pool      (pool),
        .busy      (busy),
        .result    (res)
    );

    assign done            = res.done;
    assign status          = res.status;
    assign block_order     = res.order;
    assign granted_address = res.has_addr
        ? (base_reg + res.offset + bba_pkg::ADDR_W'(HEADER_BYTES)) : '0;

endmodule

// File: hw/rtl/bba_decode.sv
`timescale 1ns / 1ps
module bba_decode #(
    parameter int MIN_ORDER    = bba_pkg::MIN_ORDER_DEF,
    parameter int HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF
) (
    input  logic [bba_pkg::REQ_W-1:0]  request_bytes,
    input  logic [bba_pkg::ADDR_W-1:0] release_address,
    input  logic [bba_pkg::ADDR_W-1:0] base_address,
    input  logic [bba_pkg::ORD_W-1:0]  pool,
    output bba_pkg::req_info_t         info
);

    localparam int NEED_W = bba_pkg::REQ_W + 1;

    logic [NEED_W-1:0]         need;
    logic [NEED_W-1:0]         need_m1;
    logic [bba_pkg::ORD_W-1:0] clog;
    logic [bba_pkg::ADDR_W-1:0] off;

    assign need    = {1'b0, request_bytes} + NEED_W'(HEADER_BYTES);
    assign need_m1 = need - NEED_W'(1);

    always_comb
    begin
        clog = '0;
        for (int i = 0; i < NEED_W; i++)
        begin
            if (need_m1[i])
            begin
                clog = bba_pkg::ORD_W'(i + 1);
            end
        end
    end

    assign off = release_address - base_address - bba_pkg::ADDR_W'(HEADER_BYTES);

    always_comb
    begin
        if (need <= (NEED_W'(1) << MIN_ORDER))
        begin
            info.want = bba_pkg::ORD_W'(MIN_ORDER);
        end
        else
        begin
            info.want = clog;
        end
        info.too_large = (info.want > pool);
        info.offset    = off;
        info.addr_bad  = ((off >> pool) != '0) || (off[MIN_ORDER-1:0] != '0);
    end

endmodule

// File: hw/rtl/bba_seq.sv
`timescale 1ns / 1ps
module bba_seq #(
    parameter int MIN_ORDER = bba_pkg::MIN_ORDER_DEF,
    parameter int MAX_ORDER = bba_pkg::MAX_ORDER_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear_req,
    input  logic                      start,
    input  logic                      kind,
    input  bba_pkg::req_info_t        info,
    input  logic [bba_pkg::ORD_W-1:0] pool,
    output logic                      busy,
    output bba_pkg::result_t          result
);

    localparam int LEVELS = MAX_ORDER - MIN_ORDER;
    localparam int LW     = LEVELS;
    localparam int NW     = LEVELS + 1;
    localparam int RL     = (NW > 5) ? 5 : LEVELS;
    localparam int RB     = 1 << RL;
    localparam int RW     = NW - RL;
    localparam int ROWS   = 1 << RW;
    localparam int LEAVES = 1 << LEVELS;
    localparam int OW     = $clog2(LEVELS + 1);
    localparam int OW_W   = bba_pkg::ORD_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_SREAD,
        S_SCHK,
        S_UPD_RD,
        S_UPD_WR,
        S_GCHK,
        S_MREAD,
        S_MCHK
    } state_t;

    state_t            state_reg;
    logic [LW-1:0]     clr_reg;
    logic [OW_W-1:0]   lvl_reg;
    logic [RW-1:0]     row_reg;
    logic [NW-1:0]     m_reg;
    logic [NW-1:0]     tgt_reg;
    logic              val_reg;
    logic              phase_free_reg;
    bba_pkg::result_t  res_reg;

    logic [RB-1:0]     node_mem_reg [ROWS];
    logic [RB-1:0]     nrd_reg;
    logic [OW:0]       grant_mem_reg [LEAVES];
    logic [OW:0]       grd_reg;

    logic              n_re;
    logic              n_we;
    logic [RW-1:0]     n_addr;
    logic [RB-1:0]     n_wdata;
    logic              g_re;
    logic              g_we;
    logic [LW-1:0]     g_addr;
    logic [OW:0]       g_wdata;

    logic [OW_W-1:0]   lw;
    logic [RB-1:0]     lvl_mask;
    logic [RB-1:0]     masked;
    logic              hit;
    logic [RL-1:0]     hit_idx;
    logic [RW-1:0]     row_last;
    logic [NW-1:0]     buddy;
    logic [NW-1:0]     j_node;
    logic [bba_pkg::ADDR_W-1:0] alloc_off;
    logic [LW-1:0]     alloc_leaf;
    logic [LW-1:0]     free_leaf;
    logic [OW_W-1:0]   f_ord;
    logic              f_ok;
    logic [bba_pkg::ADDR_W-1:0] ord_mask;
    logic [OW_W-1:0]   f_lvl;
    logic [NW-1:0]     f_m;
    logic [NW-1:0]     l_first;
    logic [NW-1:0]     l_last;

    function automatic logic [RW-1:0] first_row(input logic [OW_W-1:0] l);
        logic [NW-1:0] f;
        f = NW'(1) << l;
        return f[NW-1:RL];
    endfunction

    assign busy   = (state_reg != S_IDLE);
    assign result = res_reg;

    assign lw = pool - info.want;

    always_comb
    begin
        for (int b = 0; b < RB; b++)
        begin
            if (lvl_reg >= OW_W'(RL))
            begin
                lvl_mask[b] = 1'b1;
            end
            else
            begin
                lvl_mask[b] = ((b >> lvl_reg) == 1);
            end
        end
    end

    assign masked = nrd_reg & lvl_mask;
    assign hit    = (masked != '0);

    always_comb
    begin
        hit_idx = '0;
        for (int b = RB - 1; b >= 0; b--)
        begin
            if (masked[b])
            begin
                hit_idx = RL'(b);
            end
        end
    end

    assign l_first   = NW'(1) << lvl_reg;
    assign l_last    = (l_first << 1) - NW'(1);
    assign row_last  = l_last[NW-1:RL];
    assign buddy     = m_reg ^ NW'(1);
    assign j_node    = m_reg ^ (NW'(1) << lw);
    assign alloc_off = bba_pkg::ADDR_W'(j_node) << info.want;
    assign alloc_leaf = alloc_off[MIN_ORDER+LW-1:MIN_ORDER];
    assign free_leaf = info.offset[MIN_ORDER+LW-1:MIN_ORDER];
    assign f_ord     = OW_W'(grd_reg[OW-1:0]) + OW_W'(MIN_ORDER);
    assign ord_mask  = (bba_pkg::ADDR_W'(1) << f_ord) - bba_pkg::ADDR_W'(1);
    assign f_ok      = grd_reg[OW] && (f_ord <= pool) && ((info.offset & ord_mask) == '0);
    assign f_lvl     = pool - f_ord;
    assign f_m       = (NW'(1) << f_lvl) | NW'(info.offset >> f_ord);

    always_comb
    begin
        n_re    = 1'b0;
        n_we    = 1'b0;
        n_addr  = '0;
        n_wdata = nrd_reg;
        g_re    = 1'b0;
        g_we    = 1'b0;
        g_addr  = free_leaf;
        g_wdata = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                n_we    = 1'b1;
                n_addr  = clr_reg[RW-1:0];
                n_wdata = (clr_reg[RW-1:0] == '0) ? RB'(2) : '0;
                g_we    = 1'b1;
                g_addr  = clr_reg;
            end
            S_DECIDE:
            begin
                g_re = (kind == bba_pkg::KIND_FREE) && !info.addr_bad;
            end
            S_SREAD:
            begin
                n_re   = 1'b1;
                n_addr = row_reg;
            end
            S_UPD_RD:
            begin
                n_re   = 1'b1;
                n_addr = tgt_reg[NW-1:RL];
            end
            S_UPD_WR:
            begin
                n_we    = 1'b1;
                n_addr  = tgt_reg[NW-1:RL];
                n_wdata[tgt_reg[RL-1:0]] = val_reg;
                if (!phase_free_reg && lvl_reg == lw)
                begin
                    g_we    = 1'b1;
                    g_addr  = alloc_leaf;
                    g_wdata = {1'b1, OW'(info.want - OW_W'(MIN_ORDER))};
                end
            end
            S_GCHK:
            begin
                g_we = f_ok;
            end
            S_MREAD:
            begin
                n_re   = 1'b1;
                n_addr = buddy[NW-1:RL];
            end
            S_MCHK:
            begin
                n_addr = buddy[NW-1:RL];
                n_we   = nrd_reg[buddy[RL-1:0]];
                n_wdata[buddy[RL-1:0]] = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (n_we)
        begin
            node_mem_reg[n_addr] <= n_wdata;
        end
        if (n_re)
        begin
            nrd_reg <= node_mem_reg[n_addr];
        end
        if (g_we)
        begin
            grant_mem_reg[g_addr] <= g_wdata;
        end
        if (g_re)
        begin
            grd_reg <= grant_mem_reg[g_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            lvl_reg        <= '0;
            row_reg        <= '0;
            m_reg          <= '0;
            tgt_reg        <= '0;
            val_reg        <= 1'b0;
            phase_free_reg <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            res_reg.done <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + LW'(1);
                    if (clr_reg == LW'(LEAVES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (kind == bba_pkg::KIND_ALLOC)
                    begin
                        if (info.too_large)
                        begin
                            res_reg   <= '{1'b1, bba_pkg::ST_TOO_LARGE, '0, '0, 1'b0};
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            lvl_reg   <= lw;
                            row_reg   <= first_row(lw);
                            state_reg <= S_SREAD;
                        end
                    end
                    else if (info.addr_bad)
                    begin
                        res_reg   <= '{1'b1, bba_pkg::ST_BAD_FREE, '0, '0, 1'b0};
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_GCHK;
                    end
                end
                S_SREAD:
                begin
                    state_reg <= S_SCHK;
                end
                S_SCHK:
                begin
                    if (hit)
                    begin
                        m_reg          <= {row_reg, hit_idx};
                        tgt_reg        <= {row_reg, hit_idx};
                        val_reg        <= 1'b0;
                        phase_free_reg <= 1'b0;
                        state_reg      <= S_UPD_RD;
                    end
                    else if (row_reg != row_last)
                    begin
                        row_reg   <= row_reg + RW'(1);
                        state_reg <= S_SREAD;
                    end
                    else if (lvl_reg == '0)
                    begin
                        res_reg   <= '{1'b1, bba_pkg::ST_NO_BLOCK, '0, '0, 1'b0};
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        lvl_reg   <= lvl_reg - OW_W'(1);
                        row_reg   <= first_row(lvl_reg - OW_W'(1));
                        state_reg <= S_SREAD;
                    end
                end
                S_UPD_RD:
                begin
                    state_reg <= S_UPD_WR;
                end
                S_UPD_WR:
                begin
                    if (phase_free_reg)
                    begin
                        res_reg   <= '{1'b1, bba_pkg::ST_OK, pool - lvl_reg, '0, 1'b0};
                        state_reg <= S_IDLE;
                    end
                    else if (lvl_reg == lw)
                    begin
                        res_reg   <= '{1'b1, bba_pkg::ST_OK, info.want, alloc_off, 1'b1};
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        tgt_reg   <= {m_reg[NW-2:0], 1'b1};
                        m_reg     <= {m_reg[NW-2:0], 1'b0};
                        val_reg   <= 1'b1;
                        lvl_reg   <= lvl_reg + OW_W'(1);
                        state_reg <= S_UPD_RD;
                    end
                end
                S_GCHK:
                begin
                    if (!f_ok)
                    begin
                        res_reg   <= '{1'b1, bba_pkg::ST_BAD_FREE, '0, '0, 1'b0};
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        lvl_reg        <= f_lvl;
                        m_reg          <= f_m;
                        tgt_reg        <= f_m;
                        val_reg        <= 1'b1;
                        phase_free_reg <= 1'b1;
                        state_reg      <= (f_lvl == '0) ? S_UPD_RD : S_MREAD;
                    end
                end
                S_MREAD:
                begin
                    state_reg <= S_MCHK;
                end
                S_MCHK:
                begin
                    if (nrd_reg[buddy[RL-1:0]])
                    begin
                        m_reg     <= m_reg >> 1;
                        tgt_reg   <= m_reg >> 1;
                        lvl_reg   <= lvl_reg - OW_W'(1);
                        state_reg <= (lvl_reg == OW_W'(1)) ? S_UPD_RD : S_MREAD;
                    end
                    else
                    begin
                        tgt_reg   <= m_reg;
                        state_reg <= S_UPD_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (clear_req)
            begin
                state_reg <= S_CLEAR;
                clr_reg   <= '0;
            end
        end
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;

    localparam int MINO = bba_pkg::MIN_ORDER_DEF;
    localparam int MAXO = bba_pkg::MAX_ORDER_DEF;
    localparam int HDR = bba_pkg::HEADER_BYTES_DEF;
    localparam int LEAVES = 1 << (MAXO - MINO);
    localparam int NODES = 2 * LEAVES - 1;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [bba_pkg::ADDR_W-1:0] addr;
        bba_pkg::status_t st;
        logic [bba_pkg::ORD_W-1:0] ord;
    } grant_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic kind = bba_pkg::KIND_ALLOC;
    logic [bba_pkg::REQ_W-1:0] request_bytes = '0;
    logic [bba_pkg::ADDR_W-1:0] release_address = '0;
    logic wr_en = 1'b0;
    logic wr_index = bba_pkg::REG_POOL_ORDER;
    logic [bba_pkg::ADDR_W-1:0] wr_data = '0;
    logic busy, done;
    logic [bba_pkg::ADDR_W-1:0] granted_address;
    logic [1:0] status;
    logic [bba_pkg::ORD_W-1:0] block_order;

    buddy_block_allocator_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .kind(kind), .request_bytes(request_bytes), .release_address(release_address),
        .granted_address(granted_address), .status(status), .block_order(block_order),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    // allocator mirror
    bit tree_free [NODES];
    bit live_flag [LEAVES];
    bit [3:0] live_order [LEAVES];
    bit [4:0] pool_reg;
    bit [31:0] base_reg;
    int unsigned live_off [$];
    int unsigned freed_off [$];
    grant_beat_t pending_grants [$];

    int errors = 0;
    int n_items = 0;
    int n_grants = 0;
    int n_frees = 0;
    int n_rejects = 0;
    int stall_cycles = 0;
    bit quiet = 1'b0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int unsigned pool_size_order();
        if (pool_reg < MINO) return MINO;
        if (pool_reg > MAXO) return MAXO;
        return pool_reg;
    endfunction

    function automatic void clear_tree();
        for (int i = 0; i < NODES; i++) tree_free[i] = 1'b0;
        for (int i = 0; i < LEAVES; i++) live_flag[i] = 1'b0;
        tree_free[0] = 1'b1;
        live_off.delete();
        freed_off.delete();
    endfunction

    function automatic grant_beat_t model_alloc(int unsigned bytes);
        grant_beat_t r;
        int unsigned pool, need, want, k, n, first, cnt, offset;
        bit found;
        pool = pool_size_order();
        need = bytes + HDR;
        want = MINO;
        found = 1'b0;
        n = 0;
        r.addr = '0;
        r.ord = '0;
        while (want <= MAXO && (64'd1 << want) < need) want++;
        if (want > pool)
        begin
            r.st = bba_pkg::ST_TOO_LARGE;
            return r;
        end
        for (k = want; k <= pool; k++)
        begin
            first = (1 << (pool - k)) - 1;
            cnt = 1 << (pool - k);
            for (int j = 0; j < cnt; j++)
            begin
                if (tree_free[first + j])
                begin
                    n = first + j;
                    found = 1'b1;
                    break;
                end
            end
            if (found) break;
        end
        if (!found)
        begin
            r.st = bba_pkg::ST_NO_BLOCK;
            return r;
        end
        tree_free[n] = 1'b0;
        while (k > want)
        begin
            tree_free[2 * n + 2] = 1'b1;
            n = 2 * n + 1;
            k--;
        end
        offset = (n - ((1 << (pool - want)) - 1)) << want;
        live_flag[offset >> MINO] = 1'b1;
        live_order[offset >> MINO] = 4'(want - MINO);
        live_off.push_back(offset);
        r.addr = base_reg + offset + HDR;
        r.st = bba_pkg::ST_OK;
        r.ord = 5'(want);
        return r;
    endfunction

    function automatic grant_beat_t model_free(bit [31:0] addr);
        grant_beat_t r;
        bit [31:0] offset;
        int unsigned pool, leaf, ord, level, n, buddy;
        pool = pool_size_order();
        offset = addr - base_reg - HDR;
        r.addr = '0;
        r.ord = '0;
        r.st = bba_pkg::ST_BAD_FREE;
        if ((offset >> pool) != 0 || offset[MINO-1:0] != 0) return r;
        leaf = offset >> MINO;
        if (!live_flag[leaf]) return r;
        ord = live_order[leaf] + MINO;
        if (ord > pool || (offset & ((1 << ord) - 1)) != 0) return r;
        live_flag[leaf] = 1'b0;
        foreach (live_off[i])
        begin
            if (live_off[i] == offset)
            begin
                live_off.delete(i);
                break;
            end
        end
        freed_off.push_back(offset);
        level = pool - ord;
        n = ((1 << level) - 1) + (offset >> ord);
        while (level > 0)
        begin
            buddy = n[0] ? n + 1 : n - 1;
            if (!tree_free[buddy]) break;
            tree_free[buddy] = 1'b0;
            n = (n - 1) >> 1;
            level--;
        end
        tree_free[n] = 1'b1;
        r.st = bba_pkg::ST_OK;
        r.ord = 5'(pool - level);
        return r;
    endfunction

    task automatic send_request(bit k, bit [15:0] bytes, bit [31:0] addr);
        grant_beat_t r;
        kind <= k;
        request_bytes <= bytes;
        release_address <= addr;
        start <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy) break;
        end
        r = (k == bba_pkg::KIND_ALLOC) ? model_alloc(bytes) : model_free(addr);
        pending_grants.push_back(r);
        n_items++;
        if (r.st == bba_pkg::ST_OK)
        begin
            if (k == bba_pkg::KIND_ALLOC) n_grants++;
            else n_frees++;
        end
        else
        begin
            n_rejects++;
        end
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_grants.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(bit idx, bit [31:0] val);
        drain();
        wr_index <= idx;
        wr_data <= val;
        wr_en <= 1'b1;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == bba_pkg::REG_POOL_ORDER)
        begin
            pool_reg = val[4:0];
            clear_tree();
        end
        else
        begin
            base_reg = val;
        end
    endtask

    function automatic bit [31:0] live_addr(int unsigned off);
        return base_reg + off + HDR;
    endfunction

    task automatic test_directed();
        int unsigned p;
        write_reg(bba_pkg::REG_POOL_ORDER, 32'd6);
        write_reg(bba_pkg::REG_BASE_ADDRESS, 32'hFFFF_FFF0);
        p = pool_size_order();
        send_request(bba_pkg::KIND_ALLOC, 16'd0, '0);
        send_request(bba_pkg::KIND_ALLOC, 16'd13, '0);
        send_request(bba_pkg::KIND_ALLOC, 16'd14, '0);
        send_request(bba_pkg::KIND_ALLOC, 16'hFFFF, '0);
        send_request(bba_pkg::KIND_FREE, 16'hFFFF, live_addr(0));
        send_request(bba_pkg::KIND_FREE, 16'd0, live_addr(0));
        send_request(bba_pkg::KIND_FREE, 16'd0, live_addr(0) + 1);
        send_request(bba_pkg::KIND_FREE, 16'd0, live_addr(1 << p));
        send_request(bba_pkg::KIND_FREE, 16'd0, 32'hFFFF_FFFF);
        send_request(bba_pkg::KIND_FREE, 16'd0, live_addr(32));
        send_request(bba_pkg::KIND_ALLOC, 16'((1 << p) - HDR), '0);
        send_request(bba_pkg::KIND_ALLOC, 16'((1 << p) - HDR + 1), '0);
        send_request(bba_pkg::KIND_FREE, 16'd0, live_addr(0));
        send_request(bba_pkg::KIND_ALLOC, 16'((1 << p) - HDR), '0);
        send_request(bba_pkg::KIND_FREE, 16'd0, live_addr(0));
        write_reg(bba_pkg::REG_POOL_ORDER, 32'hFFFF_FFE0);
        send_request(bba_pkg::KIND_ALLOC, 16'd14, '0);
        send_request(bba_pkg::KIND_ALLOC, 16'd0, '0);
        write_reg(bba_pkg::REG_POOL_ORDER, 32'd31);
        write_reg(bba_pkg::REG_BASE_ADDRESS, 32'h0000_0000);
        send_request(bba_pkg::KIND_ALLOC, 16'hFFFF, '0);
        send_request(bba_pkg::KIND_ALLOC, 16'((1 << 16) - HDR), '0);
        send_request(bba_pkg::KIND_FREE, 16'd0, live_addr(0));
    endtask

    task automatic random_phase(bit [31:0] pool_val, bit [31:0] base_val, int count);
        int unsigned p, sel, idx;
        bit [15:0] bytes;
        write_reg(bba_pkg::REG_POOL_ORDER, pool_val);
        write_reg(bba_pkg::REG_BASE_ADDRESS, base_val);
        p = pool_size_order();
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55 || live_off.size() == 0)
            begin
                if ($urandom_range(0, 9) == 0) bytes = 16'($urandom);
                else bytes = 16'($urandom_range(0, (1 << p) >> 2));
                send_request(bba_pkg::KIND_ALLOC, bytes, 32'($urandom));
            end
            else if (sel < 88)
            begin
                idx = $urandom_range(0, live_off.size() - 1);
                send_request(bba_pkg::KIND_FREE, 16'($urandom), live_addr(live_off[idx]));
            end
            else if (sel < 94 && freed_off.size() != 0)
            begin
                idx = $urandom_range(0, freed_off.size() - 1);
                send_request(bba_pkg::KIND_FREE, 16'($urandom), live_addr(freed_off[idx]));
            end
            else
            begin
                send_request(bba_pkg::KIND_FREE, 16'($urandom), 32'($urandom));
            end
            if (i == count / 2) drain();
        end
    endtask

    task automatic test_random();
        random_phase(32'd5, 32'h0000_0100, 80);
        random_phase(32'd7, 32'h8000_0000, 150);
        random_phase(32'd8, 32'($urandom), 150);
        random_phase(32'd10, 32'hFFFF_FFFF, 150);
        random_phase(32'h0000_0003, 32'h1234_5678, 80);
        random_phase(32'd16, 32'($urandom), 150);
        random_phase(32'd12, 32'h0000_0000, 150);
        quiet = 1'b1;
        random_phase(32'd9, 32'hFFFF_0000, 120);
    endtask

    always @(posedge clk)
    begin
        grant_beat_t e;
        if (done)
        begin
            if (pending_grants.size() == 0)
            begin
                $display("%0t: unexpected result addr=%h status=%0d order=%0d",
                         $time, granted_address, status, block_order);
                errors++;
            end
            else
            begin
                e = pending_grants.pop_front();
                if (granted_address !== e.addr)
                begin
                    $display("%0t: granted_address expected %h actual %h",
                             $time, e.addr, granted_address);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    errors++;
                end
                if (block_order !== e.ord)
                begin
                    $display("%0t: block_order expected %0d actual %0d",
                             $time, e.ord, block_order);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_grants.size());
            $display("FAIL buddy_block_allocator_core");
            $finish;
        end
    end

    initial
    begin
        pool_reg = 5'd16;
        base_reg = '0;
        clear_tree();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random();
        drain();
        repeat (50) @(posedge clk);
        $display("covered %0d requests: %0d grants, %0d frees, %0d rejected",
                 n_items, n_grants, n_frees, n_rejects);
        $display("pool orders 3..31 incl. saturation, base addresses incl. wraparound");
        if (errors == 0)
            $display("PASS buddy_block_allocator_core");
        else
            $display("FAIL buddy_block_allocator_core");
        $finish;
    end
endmodule
